// ===== rtl/i2c_master_bit_engine_assert.svh =====
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define I2CM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication on the following clock edge.
`define I2CM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/i2cm_pkg.sv =====
package i2cm_pkg;

   typedef enum logic [4:0] {
      PH_IDLE      = 5'd0,
      PH_ST_A      = 5'd1,
      PH_ST_DLY    = 5'd2,
      PH_ST_B      = 5'd3,
      PH_RS_A      = 5'd4,
      PH_RS_D1     = 5'd5,
      PH_RS_B      = 5'd6,
      PH_RS_D2     = 5'd7,
      PH_RS_C      = 5'd8,
      PH_SP_A      = 5'd9,
      PH_SP_D1     = 5'd10,
      PH_SP_B      = 5'd11,
      PH_SP_D2     = 5'd12,
      PH_SP_C      = 5'd13,
      PH_SP_D3     = 5'd14,
      PH_WR_BIT    = 5'd15,
      PH_WR_DLY    = 5'd16,
      PH_WR_RAISE  = 5'd17,
      PH_WR_TAIL   = 5'd18,
      PH_WR_DLY2   = 5'd19,
      PH_ACK_A     = 5'd20,
      PH_ACK_DLY   = 5'd21,
      PH_ACK_RAISE = 5'd22,
      PH_ACK_END   = 5'd23,
      PH_RD_A      = 5'd24,
      PH_RD_DLY    = 5'd25,
      PH_RD_RAISE  = 5'd26,
      PH_RD_LOW    = 5'd27,
      PH_RD_DLY2   = 5'd28,
      PH_FIN       = 5'd29
   } i2cm_phase_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_START   = 3'd1,
      ACT_RESTART = 3'd2,
      ACT_STOP    = 3'd3,
      ACT_WRITE   = 3'd4,
      ACT_READ    = 3'd5
   } i2cm_action_type;

   localparam int unsigned CsrIndexWidth = 2;
   localparam logic [CsrIndexWidth-1:0] CSR_HALF_PERIOD   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_STRETCH_LIMIT = 2'd1;

   localparam logic [15:0] HALF_PERIOD_RESET   = 16'd5;
   localparam logic [15:0] STRETCH_LIMIT_RESET = 16'd1000;
   localparam logic [3:0]  BITS_PER_BYTE       = 4'd8;

   typedef struct packed {
      logic [15:0] half_period;
      logic [15:0] stretch_limit;
   } i2cm_cfg_type;

   typedef struct packed {
      i2cm_phase_type phase;
      logic [3:0]     bit_count;
      logic [7:0]     shift_reg;
      logic [15:0]    delay_count;
      logic [15:0]    stretch_count;
      logic           scl_drive;
      logic           sda_drive;
      logic [7:0]     rd_byte;
      logic           ack_flag;
      logic           to_flag;
   } i2cm_state_type;

   localparam i2cm_state_type STATE_RESET = '{
      phase:         PH_IDLE,
      bit_count:     4'd0,
      shift_reg:     8'd0,
      delay_count:   16'd0,
      stretch_count: 16'd0,
      scl_drive:     1'b1,
      sda_drive:     1'b1,
      rd_byte:       8'd0,
      ack_flag:      1'b0,
      to_flag:       1'b0
   };

endpackage

// ===== rtl/i2cm_step.sv =====
module i2cm_step import i2cm_pkg::*; (
   input  i2cm_state_type cur,
   input  i2cm_cfg_type   cfg,
   input  logic [2:0]     action,
   input  logic [7:0]     write_data,
   input  logic           sda_in,
   input  logic           scl_in,
   output i2cm_state_type nxt,
   output logic           done
);

   logic           start_cmd;
   i2cm_phase_type first_phase;
   i2cm_phase_type p0;
   i2cm_phase_type p1;
   i2cm_phase_type p2;
   logic [3:0]     bc_base;
   logic [3:0]     bc_inc;
   logic [7:0]     sr_base;
   logic [15:0]    dc_base;
   logic [15:0]    dc_inc;
   logic [15:0]    sc_base;
   logic [15:0]    sc_inc;
   logic [15:0]    hp_lim;
   logic [15:0]    sl_lim;
   logic           delay_hit;
   logic           stretch_hit;
   logic           in_delay;
   logic           in_raise;
   logic           scl_nxt;
   logic           sda_nxt;

   // Command decode; only a tick that begins idle takes a command.
   always_comb begin
      start_cmd   = 1'b0;
      first_phase = PH_IDLE;
      unique case (i2cm_action_type'(action))
         ACT_START: begin
            start_cmd   = 1'b1;
            first_phase = PH_ST_A;
         end
         ACT_RESTART: begin
            start_cmd   = 1'b1;
            first_phase = PH_RS_A;
         end
         ACT_STOP: begin
            start_cmd   = 1'b1;
            first_phase = PH_SP_A;
         end
         ACT_WRITE: begin
            start_cmd   = 1'b1;
            first_phase = PH_WR_BIT;
         end
         ACT_READ: begin
            start_cmd   = 1'b1;
            first_phase = PH_RD_A;
         end
         default: ;
      endcase
      if (cur.phase != PH_IDLE) begin
         start_cmd = 1'b0;
      end
   end

   assign bc_base = start_cmd ? 4'd0 : cur.bit_count;
   assign sr_base = start_cmd ? ((action == ACT_WRITE) ? write_data : 8'd0) : cur.shift_reg;
   assign dc_base = start_cmd ? 16'd0 : cur.delay_count;
   assign sc_base = start_cmd ? 16'd0 : cur.stretch_count;

   // A zero register acts as one.
   assign hp_lim = (cfg.half_period == 16'd0) ? 16'd1 : cfg.half_period;
   assign sl_lim = (cfg.stretch_limit == 16'd0) ? 16'd1 : cfg.stretch_limit;

   assign dc_inc      = dc_base + 16'd1;
   assign sc_inc      = sc_base + 16'd1;
   assign bc_inc      = bc_base + 4'd1;
   assign delay_hit   = (dc_inc >= hp_lim) || (dc_inc == 16'd0);
   assign stretch_hit = (sc_inc >= sl_lim) || (sc_inc == 16'd0);

   // Next phase: at most one drive step, then the wait step that takes the tick.
   always_comb begin
      p0 = start_cmd ? first_phase : cur.phase;

      p1 = p0;
      unique case (p0)
         PH_ST_A:    p1 = PH_ST_DLY;
         PH_ST_B:    p1 = PH_FIN;
         PH_RS_A:    p1 = PH_RS_D1;
         PH_RS_B:    p1 = PH_RS_D2;
         PH_RS_C:    p1 = PH_FIN;
         PH_SP_A:    p1 = PH_SP_D1;
         PH_SP_B:    p1 = PH_SP_D2;
         PH_SP_C:    p1 = PH_SP_D3;
         PH_WR_BIT:  p1 = PH_WR_DLY;
         PH_WR_TAIL: p1 = PH_WR_DLY2;
         PH_ACK_A:   p1 = PH_ACK_DLY;
         PH_ACK_END: p1 = PH_FIN;
         PH_RD_A:    p1 = PH_RD_DLY;
         PH_RD_LOW:  p1 = PH_RD_DLY2;
         default:    p1 = p0;
      endcase

      p2 = PH_IDLE;
      unique case (p1)
         PH_ST_DLY:  p2 = delay_hit ? PH_ST_B     : PH_ST_DLY;
         PH_RS_D1:   p2 = delay_hit ? PH_RS_B     : PH_RS_D1;
         PH_RS_D2:   p2 = delay_hit ? PH_RS_C     : PH_RS_D2;
         PH_SP_D1:   p2 = delay_hit ? PH_SP_B     : PH_SP_D1;
         PH_SP_D2:   p2 = delay_hit ? PH_SP_C     : PH_SP_D2;
         PH_SP_D3:   p2 = delay_hit ? PH_FIN      : PH_SP_D3;
         PH_WR_DLY:  p2 = delay_hit ? PH_WR_RAISE : PH_WR_DLY;
         PH_WR_DLY2: p2 = delay_hit ? PH_ACK_A    : PH_WR_DLY2;
         PH_ACK_DLY: p2 = delay_hit ? PH_ACK_RAISE : PH_ACK_DLY;
         PH_RD_DLY:  p2 = delay_hit ? PH_RD_RAISE : PH_RD_DLY;
         PH_RD_DLY2: begin
            if (!delay_hit) begin
               p2 = PH_RD_DLY2;
            end else begin
               p2 = (bc_base >= BITS_PER_BYTE) ? PH_FIN : PH_RD_RAISE;
            end
         end
         PH_WR_RAISE: begin
            if (scl_in) begin
               p2 = (bc_inc >= BITS_PER_BYTE) ? PH_WR_TAIL : PH_WR_BIT;
            end else begin
               p2 = stretch_hit ? PH_IDLE : PH_WR_RAISE;
            end
         end
         PH_ACK_RAISE: begin
            if (scl_in) begin
               p2 = PH_ACK_END;
            end else begin
               p2 = stretch_hit ? PH_IDLE : PH_ACK_RAISE;
            end
         end
         PH_RD_RAISE: begin
            if (scl_in) begin
               p2 = PH_RD_LOW;
            end else begin
               p2 = stretch_hit ? PH_IDLE : PH_RD_RAISE;
            end
         end
         default: p2 = PH_IDLE;
      endcase
   end

   // Drives, counters and flags.
   always_comb begin
      scl_nxt = cur.scl_drive;
      sda_nxt = cur.sda_drive;
      case (p0) inside
         PH_ST_A: begin
            scl_nxt = 1'b1;
            sda_nxt = 1'b0;
         end
         PH_RS_A: begin
            scl_nxt = 1'b1;
            sda_nxt = 1'b1;
         end
         PH_ST_B, PH_RS_C, PH_WR_TAIL, PH_ACK_END, PH_RD_LOW: scl_nxt = 1'b0;
         PH_RS_B, PH_SP_A:          sda_nxt = 1'b0;
         PH_SP_B:                   scl_nxt = 1'b1;
         PH_SP_C, PH_ACK_A, PH_RD_A: sda_nxt = 1'b1;
         PH_WR_BIT: begin
            scl_nxt = 1'b0;
            sda_nxt = sr_base[7];
         end
         default: ;
      endcase

      case (p1) inside
         PH_ST_DLY, PH_RS_D1, PH_RS_D2, PH_SP_D1, PH_SP_D2, PH_SP_D3, PH_WR_DLY,
         PH_WR_DLY2, PH_ACK_DLY, PH_RD_DLY, PH_RD_DLY2: begin
            in_delay = 1'b1;
            in_raise = 1'b0;
         end
         PH_WR_RAISE, PH_ACK_RAISE, PH_RD_RAISE: begin
            in_delay = 1'b0;
            in_raise = 1'b1;
         end
         default: begin
            in_delay = 1'b0;
            in_raise = 1'b0;
         end
      endcase

      // Release SCL for the whole stretch wait.
      if (in_raise) begin
         scl_nxt = 1'b1;
      end

      nxt.phase         = p2;
      nxt.scl_drive     = scl_nxt;
      nxt.sda_drive     = sda_nxt;
      nxt.bit_count     = bc_base;
      nxt.shift_reg     = sr_base;
      nxt.delay_count   = dc_base;
      nxt.stretch_count = sc_base;
      nxt.rd_byte       = cur.rd_byte;
      nxt.ack_flag      = start_cmd ? 1'b0 : cur.ack_flag;
      nxt.to_flag       = start_cmd ? 1'b0 : cur.to_flag;

      if (in_delay) begin
         nxt.delay_count = delay_hit ? 16'd0 : dc_inc;
      end
      if (in_raise) begin
         nxt.stretch_count = (scl_in || stretch_hit) ? 16'd0 : sc_inc;
         if (!scl_in && stretch_hit) begin
            nxt.to_flag = 1'b1;
         end
      end

      if (scl_in && (p1 == PH_WR_RAISE)) begin
         nxt.shift_reg = {sr_base[6:0], 1'b0};
         nxt.bit_count = bc_inc;
      end
      if (scl_in && (p1 == PH_RD_RAISE)) begin
         nxt.shift_reg = {sr_base[6:0], sda_in};
         nxt.bit_count = bc_inc;
      end
      if (scl_in && (p1 == PH_ACK_RAISE)) begin
         nxt.ack_flag = ~sda_in;
      end
      if ((p1 == PH_RD_DLY2) && delay_hit && (bc_base >= BITS_PER_BYTE)) begin
         nxt.rd_byte = sr_base;
      end

      // A command ends on its final step or on a stretch timeout.
      done = (p1 != PH_IDLE) && (p2 == PH_IDLE);
   end

endmodule

// ===== rtl/i2c_master_bit_engine.sv =====
// I2C master bit engine. Every req_ transaction is one tick of the bus timebase carrying
// the sampled SCL/SDA levels and, on a tick that starts idle, a command (start, repeated
// start, stop, write byte, read byte); every tick returns exactly one rsp_ transaction with
// the open-drain drives, busy/done, the last read byte, the acknowledge and a timeout flag.
// A tick is taken every clock cycle while req_ready is high: the state steps once per
// accepted tick through one combinational pass; its result lands in the response register.
// That register decouples the sides, so a new tick is taken while a result waits as long
// as rsp_ready is high in that cycle. Bus timing counts ticks, not clocks: half_period ticks
// per edge delay, up to stretch_limit ticks of SCL held low before timeout. Write the csr_
// registers (index 0 half_period, index 1 stretch_limit) only while the engine is idle.
module i2c_master_bit_engine import i2cm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [15:0]              csr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_action,
   input  logic [7:0]               req_write_data,
   input  logic                     req_sda_in,
   input  logic                     req_scl_in,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_scl_out,
   output logic                     rsp_sda_out,
   output logic                     rsp_busy_res,
   output logic                     rsp_done_res,
   output logic [7:0]               rsp_read_data,
   output logic                     rsp_ack_seen,
   output logic                     rsp_timeout
);

`include "i2c_master_bit_engine_assert.svh"

   i2cm_cfg_type   cfg_ff;
   i2cm_state_type state_ff;
   i2cm_state_type state_in;
   logic           done_in;
   logic           req_accept;
   logic           rsp_valid_ff;
   logic           scl_out_ff;
   logic           sda_out_ff;
   logic           busy_ff;
   logic           done_ff;
   logic [7:0]     read_data_ff;
   logic           ack_seen_ff;
   logic           timeout_ff;

   assign csr_ready  = 1'b1;
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   i2cm_step u_step (
      .cur        (state_ff),
      .cfg        (cfg_ff),
      .action     (req_action),
      .write_data (req_write_data),
      .sda_in     (req_sda_in),
      .scl_in     (req_scl_in),
      .nxt        (state_in),
      .done       (done_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period   <= HALF_PERIOD_RESET;
         cfg_ff.stretch_limit <= STRETCH_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HALF_PERIOD:   cfg_ff.half_period   <= csr_data;
            CSR_STRETCH_LIMIT: cfg_ff.stretch_limit <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         scl_out_ff   <= state_in.scl_drive;
         sda_out_ff   <= state_in.sda_drive;
         busy_ff      <= (state_in.phase != PH_IDLE);
         done_ff      <= done_in;
         read_data_ff <= state_in.rd_byte;
         ack_seen_ff  <= state_in.ack_flag;
         timeout_ff   <= state_in.to_flag;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_out   = scl_out_ff;
   assign rsp_sda_out   = sda_out_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_done_res  = done_ff;
   assign rsp_read_data = read_data_ff;
   assign rsp_ack_seen  = ack_seen_ff;
   assign rsp_timeout   = timeout_ff;

   `I2CM_ASSERT_NOW(a_done_not_busy, clock, reset, rsp_valid_ff && done_ff, !busy_ff,
      "command reported done while still busy")
   `I2CM_ASSERT_NOW(a_busy_tracks_phase, clock, reset, rsp_valid_ff,
      busy_ff == (state_ff.phase != PH_IDLE), "busy result disagrees with engine phase")
   `I2CM_ASSERT_NOW(a_timeout_ends_cmd, clock, reset, $rose(state_ff.to_flag),
      rsp_valid_ff && done_ff && !busy_ff, "timeout raised without ending the command")
   `I2CM_ASSERT_NOW(a_bit_count_range, clock, reset, 1'b1,
      state_ff.bit_count <= BITS_PER_BYTE, "bit counter ran past one byte")
   `I2CM_ASSERT_NEXT(a_idle_without_tick, clock, reset,
      !req_accept && (state_ff.phase == PH_IDLE), state_ff.phase == PH_IDLE,
      "engine left idle without an accepted tick")

endmodule
